// ----- rtl/nrd_pkg.sv -----
package nrd_pkg;

  localparam int RING_BYTES = 32768;

  localparam int OFFSET_W = 15;
  localparam int LEN_W = 14;
  localparam int STATUS_W = 16;
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 14;
  localparam int OUT_DATA_W = 56;

  localparam logic [15:0] LEN_MIN = 16'd60;
  localparam logic [LEN_W-1:0] CRC_BYTES = 14'd4;
  localparam logic [STATUS_W-1:0] STATUS_OK = 16'h0001;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 14'd16379;

  localparam logic [CFG_INDEX_W-1:0] CFG_RX_ENABLE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEN = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD    = 2'd0,
    KIND_FRAME_END  = 2'd1,
    KIND_BAD_HEADER = 2'd2
  } kind_t;

  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_BODY   = 1'b1
  } phase_t;

  typedef struct packed {
    kind_t                kind;
    logic [BYTE_W-1:0]    data_byte;
    logic [LEN_W-1:0]     frame_length;
    logic [OFFSET_W-1:0]  next_offset;
    logic [STATUS_W-1:0]  status_word;
  } result_t;

endpackage

// ----- rtl/nrd_parser.sv -----
module nrd_parser
  import nrd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_take,
  input  logic [BYTE_W-1:0]      in_byte,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output logic                   res_valid,
  output result_t                res
);

  logic               rx_enable;
  logic [LEN_W-1:0]   max_len;

  phase_t             phase, phase_next;
  logic [1:0]         header_index, header_index_next;
  logic [STATUS_W-1:0] header_status, header_status_next;
  logic [LEN_W-1:0]   header_length, header_length_next;
  logic [LEN_W-1:0]   bytes_left, bytes_left_next;
  logic [LEN_W-1:0]   payload_count, payload_count_next;
  logic [OFFSET_W-1:0] ring_offset, ring_offset_next;

  logic [16:0]        off_inc;
  logic [15:0]        len16;
  logic               bad_header;
  logic [LEN_W-1:0]   pkt_full;
  logic [LEN_W-1:0]   pkt;
  logic [14:0]        len_round;
  logic               step;

  assign step = in_take && rx_enable;

  assign off_inc = {2'b00, ring_offset} + 17'd1;
  assign ring_offset_next = (off_inc == 17'(RING_BYTES)) ? '0 : off_inc[OFFSET_W-1:0];

  assign len16 = {in_byte, header_length[7:0]};
  assign bad_header = ((header_status & STATUS_OK) == '0) || (len16 < LEN_MIN)
                      || (in_byte[7:6] != 2'b00);
  assign pkt_full = len16[LEN_W-1:0] - CRC_BYTES;
  assign pkt = (pkt_full > max_len) ? max_len : pkt_full;
  // round header plus length (CRC included) up to the next dword boundary
  assign len_round = ({1'b0, len16[LEN_W-1:0]} + 15'd7) & ~15'd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable <= 1'b0;
      max_len   <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_RX_ENABLE: rx_enable <= cfg_wdata[0];
        CFG_MAX_LEN:   max_len   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_next         = phase;
    header_index_next  = header_index;
    header_status_next = header_status;
    header_length_next = header_length;
    bytes_left_next    = bytes_left;
    payload_count_next = payload_count;
    if (phase == PH_HEADER) begin
      unique case (header_index)
        2'd0: begin
          header_status_next = {8'h00, in_byte};
          header_index_next  = 2'd1;
        end
        2'd1: begin
          header_status_next = {in_byte, header_status[7:0]};
          header_index_next  = 2'd2;
        end
        2'd2: begin
          header_length_next = {6'd0, in_byte};
          header_index_next  = 2'd3;
        end
        default: begin
          header_index_next = 2'd0;
          if (bad_header) begin
            header_length_next = '0;
          end else begin
            header_length_next = pkt;
            payload_count_next = pkt;
            bytes_left_next    = LEN_W'(len_round - 15'd5);
            phase_next         = PH_BODY;
          end
        end
      endcase
    end else begin
      if (bytes_left == '0) begin
        phase_next         = PH_HEADER;
        header_index_next  = 2'd0;
        payload_count_next = '0;
      end else begin
        bytes_left_next = bytes_left - 14'd1;
        if (payload_count != '0) begin
          payload_count_next = payload_count - 14'd1;
        end
      end
    end
  end

  // result for this item
  always_comb begin
    res_valid = 1'b0;
    res       = '{kind: KIND_PAYLOAD, data_byte: '0, frame_length: '0,
                  next_offset: '0, status_word: '0};
    if (step) begin
      if (phase == PH_HEADER) begin
        if (header_index == 2'd3 && bad_header) begin
          res_valid       = 1'b1;
          res.kind        = KIND_BAD_HEADER;
          res.next_offset = ring_offset_next;
          res.status_word = header_status;
        end
      end else if (bytes_left == '0) begin
        res_valid        = 1'b1;
        res.kind         = KIND_FRAME_END;
        res.frame_length = header_length;
        res.next_offset  = ring_offset_next;
        res.status_word  = header_status;
      end else if (payload_count != '0) begin
        res_valid     = 1'b1;
        res.kind      = KIND_PAYLOAD;
        res.data_byte = in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      header_index  <= '0;
      header_status <= '0;
      header_length <= '0;
      bytes_left    <= '0;
      payload_count <= '0;
      ring_offset   <= '0;
    end else if (step) begin
      phase         <= phase_next;
      header_index  <= header_index_next;
      header_status <= header_status_next;
      header_length <= header_length_next;
      bytes_left    <= bytes_left_next;
      payload_count <= payload_count_next;
      ring_offset   <= ring_offset_next;
    end
  end

endmodule

// ----- rtl/nrd_out_stage.sv -----
module nrd_out_stage
  import nrd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  input  result_t res,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    skid_valid;
  result_t skid_res;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      // output slot frees up: drain the skid first
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
        out_res   <= res;
      end
    end else if (res_valid) begin
      // hold the new item while the output stalls
      skid_valid <= 1'b1;
      skid_res   <= res;
    end
  end

endmodule

// ----- rtl/nic_rx_ring_deframer.sv -----
// Channel   Dir  Signals                         Payload
// s_axis    in   tvalid tready tdata[7:0]        ring_byte
// m_axis    out  tvalid tready tdata[55:0] tuser kind; data/length/offset/status
// cfg       in   valid ready index data          0 rx_enable, 1 max_len
//
// One ring byte per cycle while s_axis_tready is high; results are registered.
// The parser state is a single register set updated per byte taken with rx_enable set.
// A two-entry output register with skid keeps s_axis_tready up during an m_axis
// stall; it drops only when both entries are full.
// rst is synchronous: header phase, offset zero, receiver disabled.
module nic_rx_ring_deframer
  import nrd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] ring_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // [7:0] data_byte, [21:8] frame_length,
                                                 // [36:22] next_offset, [52:37] status_word
  output logic [KIND_W-1:0]      m_axis_tuser,   // [1:0] kind
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    in_ready;

  assign s_axis_tready = in_ready;
  assign cfg_ready     = 1'b1;

  nrd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_take   (s_axis_tvalid && in_ready),
    .in_byte   (s_axis_tdata),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  nrd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .in_ready  (in_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {3'b000, out_res.status_word, out_res.next_offset,
                         out_res.frame_length, out_res.data_byte};
  assign m_axis_tuser = out_res.kind;

endmodule

// ----- test/nic_rx_ring_deframer_test.sv -----
module nic_rx_ring_deframer_test;
  import nrd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_LEN_MAX = 16'h3FFF;
  localparam int RANDOM_ITEMS = 650;
  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_LINES = 40;

  class deframe_scoreboard;
    bit                  rx_on;
    logic [LEN_W-1:0]    len_cap;
    phase_t              ph;
    logic [1:0]          hdr_idx;
    logic [STATUS_W-1:0] hdr_status;
    logic [LEN_W-1:0]    hdr_len;
    logic [LEN_W-1:0]    body_left;
    logic [LEN_W-1:0]    payload_left;
    logic [OFFSET_W-1:0] offset;
    result_t             pending_results[$];
    int                  mismatches;

    function new();
      rx_on = 1'b0;
      len_cap = MAX_LEN_RESET;
      ph = PH_HEADER;
      hdr_idx = '0;
      hdr_status = '0;
      hdr_len = '0;
      body_left = '0;
      payload_left = '0;
      offset = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_RX_ENABLE)
        rx_on = val[0];
      else if (idx == CFG_MAX_LEN)
        len_cap = val;
    endfunction

    function void expect_result(kind_t k, logic [BYTE_W-1:0] d, logic [LEN_W-1:0] flen,
                                logic [OFFSET_W-1:0] noff, logic [STATUS_W-1:0] stat);
      result_t r;
      r.kind = k;
      r.data_byte = d;
      r.frame_length = flen;
      r.next_offset = noff;
      r.status_word = stat;
      pending_results.push_back(r);
    endfunction

    // Advance the parser by one accepted ring byte.
    function void predict_ring_byte(logic [BYTE_W-1:0] b);
      int full_len;
      int deliver;
      if (!rx_on)
        return;
      offset = OFFSET_W'((int'(offset) + 1) % RING_BYTES);
      if (ph == PH_HEADER) begin
        case (hdr_idx)
          2'd0: begin
            hdr_status = {8'h00, b};
            hdr_idx = 2'd1;
          end
          2'd1: begin
            hdr_status[15:8] = b;
            hdr_idx = 2'd2;
          end
          2'd2: begin
            hdr_len = {6'd0, b};
            hdr_idx = 2'd3;
          end
          default: begin
            hdr_idx = 2'd0;
            full_len = {b, hdr_len[7:0]};
            if ((hdr_status & STATUS_OK) == 0 || full_len < LEN_MIN ||
                full_len > FRAME_LEN_MAX) begin
              hdr_len = '0;
              expect_result(KIND_BAD_HEADER, '0, '0, offset, hdr_status);
            end else begin
              deliver = full_len - CRC_BYTES;
              if (deliver > len_cap)
                deliver = len_cap;
              hdr_len = LEN_W'(deliver);
              payload_left = LEN_W'(deliver);
              // body runs through the CRC and up to the next dword boundary
              body_left = LEN_W'(((full_len + 7) & ~3) - 5);
              ph = PH_BODY;
            end
          end
        endcase
      end else if (body_left == 0) begin
        ph = PH_HEADER;
        hdr_idx = 2'd0;
        payload_left = '0;
        expect_result(KIND_FRAME_END, '0, hdr_len, offset, hdr_status);
      end else begin
        body_left = body_left - 1'b1;
        if (payload_left > 0) begin
          payload_left = payload_left - 1'b1;
          expect_result(KIND_PAYLOAD, b, '0, '0, '0);
        end
      end
    endfunction

    task note_mismatch(string what);
      mismatches++;
      if (mismatches <= REPORT_LINES)
        $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_result(logic [KIND_W-1:0] k, logic [OUT_DATA_W-1:0] d);
      result_t want;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result kind %0d tdata %h", k, d));
        return;
      end
      want = pending_results.pop_front();
      if (k !== want.kind)
        note_mismatch($sformatf("kind %0d, expected %0d", k, want.kind));
      if (d[7:0] !== want.data_byte)
        note_mismatch($sformatf("data_byte %h, expected %h", d[7:0], want.data_byte));
      if (d[21:8] !== want.frame_length)
        note_mismatch($sformatf("frame_length %0d, expected %0d", d[21:8],
                                want.frame_length));
      if (d[36:22] !== want.next_offset)
        note_mismatch($sformatf("next_offset %0d, expected %0d", d[36:22],
                                want.next_offset));
      if (d[52:37] !== want.status_word)
        note_mismatch($sformatf("status_word %h, expected %h", d[52:37],
                                want.status_word));
      if (d[55:53] !== 3'b000)
        note_mismatch($sformatf("tdata fill bits %b, expected zero", d[55:53]));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [BYTE_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0] m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  deframe_scoreboard sb = new;
  logic [BYTE_W-1:0] ring_image[$];
  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;
  int stall_cycles = 0;

  nic_rx_ring_deframer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4ns clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        sb.set_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        sb.predict_ring_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result sink: when sink_idle is set, hold tready low for a random stretch before each item.
  initial begin
    int n;
    do @(posedge clk); while (rst);
    forever begin
      n = sink_idle ? $urandom_range(0, 13) : 0;
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic send_byte(logic [BYTE_W-1:0] b);
    int gap;
    gap = src_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_ring();
    while (ring_image.size() > 0)
      send_byte(ring_image.pop_front());
  endtask

  // Stop the stream, wait for every expected result, then let the pipeline settle.
  task automatic drain(int settle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic queue_frame(logic [15:0] status, logic [15:0] len);
    int body;
    ring_image.push_back(status[7:0]);
    ring_image.push_back(status[15:8]);
    ring_image.push_back(len[7:0]);
    ring_image.push_back(len[15:8]);
    if (status[0] && len >= LEN_MIN && len <= FRAME_LEN_MAX) begin
      body = ((int'(len) + 7) & ~3) - 4;
      repeat (body) ring_image.push_back(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // Send part of the ring, drop the receiver for a few junk bytes, then resume.
  task automatic send_with_outage(int cut);
    int junk;
    repeat (cut) send_byte(ring_image.pop_front());
    drain(4);
    write_reg(CFG_RX_ENABLE, '0);
    junk = $urandom_range(1, 6);
    repeat (junk) send_byte(BYTE_W'($urandom));
    drain(4);
    write_reg(CFG_RX_ENABLE, CFG_DATA_W'(1));
    send_ring();
  endtask

  task automatic queue_random_frame();
    logic [15:0] status;
    logic [15:0] len;
    if ($urandom_range(0, 9) < 8) begin
      status = 16'($urandom) | STATUS_OK;
      if ($urandom_range(0, 15) == 0)
        len = 16'($urandom_range(141, 600));
      else
        len = 16'($urandom_range(60, 140));
    end else begin
      status = 16'($urandom);
      if (!status[0])
        len = 16'($urandom);
      else if ($urandom_range(0, 1) == 0)
        len = 16'($urandom_range(0, 59));
      else
        len = 16'($urandom_range(16384, 65535));
    end
    queue_frame(status, len);
  endtask

  initial begin
    int sent;
    int nframes;
    int count;
    logic [CFG_DATA_W-1:0] cap;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // receiver still disabled after reset: these bytes go nowhere
    repeat (8) ring_image.push_back(BYTE_W'($urandom));
    send_ring();
    drain(4);
    write_reg(CFG_RX_ENABLE, CFG_DATA_W'(1));

    // bad headers: status not OK, length too short, too long, all ones
    queue_frame(16'h0000, 16'd60);
    queue_frame(16'hFFFE, 16'h3FFF);
    queue_frame(16'h0001, 16'd59);
    queue_frame(16'h0001, 16'h4000);
    queue_frame(16'hFFFF, 16'hFFFF);
    // good frames at the shortest lengths, one per padding amount
    queue_frame(16'hFFFF, 16'd60);
    queue_frame(16'h8001, 16'd61);
    queue_frame(16'h0001, 16'd62);
    queue_frame(16'h0101, 16'd63);
    send_ring();
    drain(4);

    write_reg(CFG_MAX_LEN, '0);
    queue_frame(16'h0001, 16'd64);
    send_ring();
    drain(4);
    write_reg(CFG_MAX_LEN, '1);
    queue_frame(16'h0003, 16'd70);
    send_with_outage(37);
    drain(4);

    // longer frames back to back, full delivery then truncated
    src_idle = 1'b0;
    sink_idle = 1'b0;
    write_reg(CFG_MAX_LEN, MAX_LEN_RESET);
    queue_frame(16'h0001, 16'd256);
    send_ring();
    drain(4);
    write_reg(CFG_MAX_LEN, CFG_DATA_W'(5));
    queue_frame(16'hF00D, 16'd256);
    send_ring();
    drain(4);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: cap = '0;
        1: cap = MAX_LEN_RESET;
        2: cap = '1;
        3: cap = CFG_DATA_W'($urandom_range(1, 16));
        default: cap = CFG_DATA_W'($urandom);
      endcase
      write_reg(CFG_MAX_LEN, cap);
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_RX_ENABLE, CFG_DATA_W'($urandom) | CFG_DATA_W'(1));
      src_idle = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      nframes = $urandom_range(1, 6);
      repeat (nframes) queue_random_frame();
      count = ring_image.size();
      if ($urandom_range(0, 4) == 0 && count > 8)
        send_with_outage($urandom_range(1, count - 1));
      else
        send_ring();
      sent += count;
      drain(4);
    end

    drain(8);
    if (sb.pending() != 0)
      sb.note_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/nrd_pkg.sv
rtl/nrd_parser.sv
rtl/nrd_out_stage.sv
rtl/nic_rx_ring_deframer.sv
test/nic_rx_ring_deframer_test.sv
